// ----- design/fpld_pkg.sv -----
// Package for the fixed-point log / dB unit: constants, the work word
// passed between pipeline sections, and the rounding Q-multiply helper.
// No dependencies.
package fpld_pkg;

   localparam logic signed [31:0] INV_SQRT2_Q30      = 32'sd759250112;
   localparam logic signed [31:0] POLY_C5_Q26        = 32'sd75959200;
   localparam logic signed [31:0] EXP_TO_LOG10_Q26   = 32'sd20201782;
   localparam logic signed [31:0] SQRT2_EXP_STEP_Q25 = 32'sd16777216;
   localparam logic signed [31:0] FLOOR_DB_Q21       = -32'sd2097151999;
   localparam logic signed [31:0] LN10_Q29           = 32'sd1236190976;
   localparam logic signed [31:0] FLOOR_LN_Q26       = -32'sd2013265919;
   localparam logic signed [31:0] TWENTY_Q26         = 32'sd1342177280;

   // Horner steps, applied after the leading coefficient
   localparam int NUM_STEPS = 5;
   localparam logic signed [31:0] HORNER_COEF [NUM_STEPS] = '{
      -32'sd285795039,
       32'sd457435200,
      -32'sd410610303,
       32'sd244982704,
      -32'sd81731487
   };

   // mode codes
   localparam logic MODE_DB = 1'b0;
   localparam logic MODE_LN = 1'b1;

   typedef struct packed {
      logic              mode;      // MODE_DB or MODE_LN
      logic              floor_out; // input was zero or negative
      logic signed [31:0] mant;     // mantissa, Q30
      logic signed [31:0] ex_term;  // exponent times log10(2), Q26
      logic signed [31:0] acc;      // Horner accumulator, Q26
   } fpld_work_type;

   // round to nearest (ties up) after a right shift by s, keep low 32 bits
   function automatic logic signed [31:0] qround(input logic signed [63:0] p,
                                                 input int s);
      logic signed [63:0] bias;
      logic signed [63:0] rnd;
      bias = 64'sd1 <<< (s - 1);
      rnd  = (p + bias) >>> s;
      return rnd[31:0];
   endfunction

endpackage

// ----- design/fpld_req_if.sv -----
// Request channel of the log / dB unit: valid, ready and the input word.
// No dependencies.
interface fpld_req_if;
   logic              valid;
   logic              ready;
   logic              req_type;
   logic signed [31:0] x_value;

   modport source (output valid, req_type, x_value, input ready);
   modport sink   (input valid, req_type, x_value, output ready);
endinterface

// ----- design/fpld_rsp_if.sv -----
// Response channel of the log / dB unit: valid, ready and the result word.
// No dependencies.
interface fpld_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [31:0] log_value;

   modport source (output valid, log_value, input ready);
   modport sink   (input valid, log_value, output ready);
endinterface

// ----- design/fpld_norm.sv -----
// Normalize section: leading-one search, mantissa shift, 1/sqrt2 scaling
// and exponent term. Four register stages. Depends on fpld_pkg.
module fpld_norm
   import fpld_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic              in_type,
   input  logic signed [31:0] in_x,
   output logic              out_valid,
   input  logic              out_ready,
   output fpld_work_type     out_work
);

   logic [3:0] vld_ff;
   logic [3:0] adv;

   // stage 0: leading-one position
   logic              s0_type_ff;
   logic              s0_floor_ff;
   logic [30:0]       s0_x_ff;
   logic [4:0]        s0_pos_ff;
   logic [4:0]        s0_pos_in;

   // stage 1: shifted mantissa, exponent
   logic              s1_type_ff;
   logic              s1_floor_ff;
   logic              s1_big_ff;
   logic [30:0]       s1_mant_ff;
   logic signed [31:0] s1_ex_ff;
   logic [4:0]        shamt;
   logic [30:0]       s1_mant_in;
   logic              s1_big_in;
   logic signed [6:0] ex_exp;
   logic signed [31:0] s1_ex_in;

   // stage 2: products
   logic              s2_type_ff;
   logic              s2_floor_ff;
   logic              s2_big_ff;
   logic [30:0]       s2_mant_ff;
   logic signed [63:0] s2_pm_ff;
   logic signed [63:0] s2_pe_ff;

   fpld_work_type     out_work_ff;
   fpld_work_type     out_work_in;

   assign adv[3]   = !vld_ff[3] || out_ready;
   assign adv[2]   = !vld_ff[2] || adv[3];
   assign adv[1]   = !vld_ff[1] || adv[2];
   assign adv[0]   = !vld_ff[0] || adv[1];
   assign in_ready = adv[0];
   assign out_valid = vld_ff[3];
   assign out_work  = out_work_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) vld_ff[0] <= in_valid;
         if (adv[1]) vld_ff[1] <= vld_ff[0];
         if (adv[2]) vld_ff[2] <= vld_ff[1];
         if (adv[3]) vld_ff[3] <= vld_ff[2];
      end
   end

   always_comb begin
      s0_pos_in = '0;
      for (int i = 0; i < 31; i++) begin
         if (in_x[i]) s0_pos_in = 5'(i + 1);
      end
   end

   always_comb begin
      shamt = 5'(5'd30 - s0_pos_ff);
      if (s0_pos_ff == 5'd31) begin
         s1_mant_in = 31'(({1'b0, s0_x_ff} + 32'd1) >> 1);
      end else begin
         s1_mant_in = s0_x_ff << shamt;
      end
      s1_big_in = $signed({1'b0, s1_mant_in}) > INV_SQRT2_Q30;
      ex_exp    = $signed({2'b00, s0_pos_ff}) - 7'sd26;
      s1_ex_in  = (32'(ex_exp) <<< 25) + (s1_big_in ? SQRT2_EXP_STEP_Q25 : 32'sd0);
   end

   always_comb begin
      out_work_in.mode      = s2_type_ff;
      out_work_in.floor_out = s2_floor_ff;
      out_work_in.mant      = s2_big_ff ? qround(s2_pm_ff, 30)
                                        : $signed({1'b0, s2_mant_ff});
      out_work_in.ex_term   = qround(s2_pe_ff, 25);
      out_work_in.acc       = POLY_C5_Q26;
   end

   always_ff @(posedge clock) begin
      if (adv[0] && in_valid) begin
         s0_type_ff  <= in_type;
         s0_floor_ff <= in_x[31] || (in_x == 32'sd0);
         s0_x_ff     <= in_x[30:0];
         s0_pos_ff   <= s0_pos_in;
      end
      if (adv[1] && vld_ff[0]) begin
         s1_type_ff  <= s0_type_ff;
         s1_floor_ff <= s0_floor_ff;
         s1_big_ff   <= s1_big_in;
         s1_mant_ff  <= s1_mant_in;
         s1_ex_ff    <= s1_ex_in;
      end
      if (adv[2] && vld_ff[1]) begin
         s2_type_ff  <= s1_type_ff;
         s2_floor_ff <= s1_floor_ff;
         s2_big_ff   <= s1_big_ff;
         s2_mant_ff  <= s1_mant_ff;
         s2_pm_ff    <= 64'($signed({1'b0, s1_mant_ff})) * 64'(INV_SQRT2_Q30);
         s2_pe_ff    <= 64'(s1_ex_ff) * 64'(EXP_TO_LOG10_Q26);
      end
      if (adv[3] && vld_ff[2]) begin
         out_work_ff <= out_work_in;
      end
   end

endmodule

// ----- design/fpld_horner.sv -----
// One Horner step: multiply the accumulator by the mantissa, round, add
// the step coefficient. Two register stages. Depends on fpld_pkg.
module fpld_horner
   import fpld_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic signed [31:0] coef_in,
   input  logic              in_valid,
   output logic              in_ready,
   input  fpld_work_type     in_work,
   output logic              out_valid,
   input  logic              out_ready,
   output fpld_work_type     out_work
);

   logic              vld_a_ff;
   logic              vld_b_ff;
   logic              adv_a;
   logic              adv_b;
   logic signed [63:0] prod_ff;
   logic signed [63:0] prod_in;
   fpld_work_type     work_a_ff;
   fpld_work_type     work_b_ff;
   fpld_work_type     work_b_in;

   assign adv_b     = !vld_b_ff || out_ready;
   assign adv_a     = !vld_a_ff || adv_b;
   assign in_ready  = adv_a;
   assign out_valid = vld_b_ff;
   assign out_work  = work_b_ff;

   assign prod_in = 64'($signed(in_work.acc)) * 64'($signed(in_work.mant));

   always_comb begin
      work_b_in     = work_a_ff;
      work_b_in.acc = qround(prod_ff, 30) + coef_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
      end else begin
         if (adv_a) vld_a_ff <= in_valid;
         if (adv_b) vld_b_ff <= vld_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_a && in_valid) begin
         work_a_ff <= in_work;
         prod_ff   <= prod_in;
      end
      if (adv_b && vld_a_ff) begin
         work_b_ff <= work_b_in;
      end
   end

endmodule

// ----- design/fpld_scale.sv -----
// Output section: add the exponent term, scale by 20 or ln(10), round and
// substitute the floor for non-positive inputs. Depends on fpld_pkg.
module fpld_scale
   import fpld_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  fpld_work_type     in_work,
   output logic              out_valid,
   input  logic              out_ready,
   output logic signed [31:0] out_value
);

   logic [2:0]        vld_ff;
   logic [2:0]        adv;

   logic              t0_mode_ff;
   logic              t0_floor_ff;
   logic signed [31:0] t0_sum_ff;

   logic              t1_mode_ff;
   logic              t1_floor_ff;
   logic signed [63:0] t1_prod_ff;
   logic signed [31:0] factor;

   logic signed [31:0] log_ff;
   logic signed [31:0] log_in;

   assign adv[2]    = !vld_ff[2] || out_ready;
   assign adv[1]    = !vld_ff[1] || adv[2];
   assign adv[0]    = !vld_ff[0] || adv[1];
   assign in_ready  = adv[0];
   assign out_valid = vld_ff[2];
   assign out_value = log_ff;

   assign factor = (t0_mode_ff == MODE_LN) ? LN10_Q29 : TWENTY_Q26;

   always_comb begin
      if (t1_floor_ff) begin
         log_in = (t1_mode_ff == MODE_LN) ? FLOOR_LN_Q26 : FLOOR_DB_Q21;
      end else if (t1_mode_ff == MODE_LN) begin
         log_in = qround(t1_prod_ff, 29);
      end else begin
         log_in = qround(t1_prod_ff, 31);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) vld_ff[0] <= in_valid;
         if (adv[1]) vld_ff[1] <= vld_ff[0];
         if (adv[2]) vld_ff[2] <= vld_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0] && in_valid) begin
         t0_mode_ff  <= in_work.mode;
         t0_floor_ff <= in_work.floor_out;
         t0_sum_ff   <= in_work.acc + in_work.ex_term;
      end
      if (adv[1] && vld_ff[0]) begin
         t1_mode_ff  <= t0_mode_ff;
         t1_floor_ff <= t0_floor_ff;
         t1_prod_ff  <= 64'(t0_sum_ff) * 64'(factor);
      end
      if (adv[2] && vld_ff[1]) begin
         log_ff <= log_in;
      end
   end

endmodule

// ----- design/fixed_point_log_db_top.sv -----
// Top level of the fixed-point log / dB unit.
// Depends on fpld_pkg, fpld_req_if, fpld_rsp_if, fpld_norm, fpld_horner,
// fpld_scale.
//
//   channel   | dir | handshake          | word
//   ----------+-----+--------------------+------------------------------------
//   req_bus   | in  | valid/ready        | req_type (0 dB, 1 ln), x_value Q6.26
//   rsp_bus   | out | valid/ready        | log_value (dB Q21 or ln Q26)
//
// One word per cycle in and out while rsp_bus is not stalled; the pipe
// holds a chain of seven rounded 32x32 multiplies (sqrt2 scaling, five
// Horner steps, final scaling), each followed by its own register.
// Every stage carries a valid bit and holds its word until the next stage
// can take it, so a stall on rsp_bus backs up stage by stage; bubbles in
// the pipe still let new words in while a result waits at the output.
// Synchronous reset clears the valid bits only.
module fixed_point_log_db_top
   import fpld_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   fpld_req_if.sink  req_bus,
   fpld_rsp_if.source rsp_bus
);

   // section links: index 0 is norm output, index k+1 is Horner step k output
   logic          link_valid [NUM_STEPS + 1];
   logic          link_ready [NUM_STEPS + 1];
   fpld_work_type link_work  [NUM_STEPS + 1];

   // normalize, scale by 1/sqrt2 where needed, form exponent term
   fpld_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_type   (req_bus.req_type),
      .in_x      (req_bus.x_value),
      .out_valid (link_valid[0]),
      .out_ready (link_ready[0]),
      .out_work  (link_work[0])
   );

   // polynomial in the mantissa, one Horner step per section
   for (genvar k = 0; k < NUM_STEPS; k++) begin : g_step
      fpld_horner u_horner (
         .clock     (clock),
         .reset     (reset),
         .coef_in   (HORNER_COEF[k]),
         .in_valid  (link_valid[k]),
         .in_ready  (link_ready[k]),
         .in_work   (link_work[k]),
         .out_valid (link_valid[k + 1]),
         .out_ready (link_ready[k + 1]),
         .out_work  (link_work[k + 1])
      );
   end

   // add exponent term, scale to dB or ln, apply floor; output register
   fpld_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (link_valid[NUM_STEPS]),
      .in_ready  (link_ready[NUM_STEPS]),
      .in_work   (link_work[NUM_STEPS]),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_value (rsp_bus.log_value)
   );

   // an empty or draining output stage must open the whole pipe to input
   a_open_when_drained : assert property (@(posedge clock) disable iff (reset)
      (!rsp_bus.valid || rsp_bus.ready) |-> req_bus.ready)
      else $error("input blocked although output stage can advance");

   // reset empties the pipe
   a_empty_after_reset : assert property (@(posedge clock)
      reset |=> !rsp_bus.valid)
      else $error("result valid right after reset");

   // a stalled result holds its word until taken
   a_hold_on_stall : assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.ready) |=>
         (rsp_bus.valid && $stable(rsp_bus.log_value)))
      else $error("result dropped or changed while stalled");

endmodule
